// File: sv/drum_trigger_peak_detector_unit_defines.svh
// ----------------------------------------------------------------------------
// drum trigger peak detector assertion macros
// Shared assertion shorthands clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DRUM_TRIGGER_PEAK_DETECTOR_UNIT_DEFINES_SVH
`define DRUM_TRIGGER_PEAK_DETECTOR_UNIT_DEFINES_SVH

// same-cycle implication
`define DTPD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DTPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/dtpd_pkg.sv
// ----------------------------------------------------------------------------
// dtpd_pkg
// Types and constants shared by the drum trigger peak detector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dtpd_pkg;

  // field widths
  localparam int SAMPLE_W = 10;
  localparam int LEVEL_W  = 9;
  localparam int SLOPE_W  = 7;
  localparam int VEL_W    = 7;
  localparam int NOTE_W   = 7;
  localparam int STATUS_W = 8;
  localparam int THRESH_W = 7;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  // clip ceiling of the level
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 9'd511;

  // register indexes
  localparam logic [1:0] REG_DC_OFFSET  = 2'd0;
  localparam logic [1:0] REG_THRESHOLD  = 2'd1;
  localparam logic [1:0] REG_NOTE       = 2'd2;
  localparam logic [1:0] REG_STATUS     = 2'd3;

  // register reset values
  localparam logic [SAMPLE_W-1:0] RST_DC_OFFSET = 10'd512;
  localparam logic [THRESH_W-1:0] RST_THRESHOLD = 7'd5;
  localparam logic [NOTE_W-1:0]   RST_NOTE      = 7'd62;
  localparam logic [STATUS_W-1:0] RST_STATUS    = 8'h90;

  // configuration seen by the datapath
  typedef struct packed {
    logic [SAMPLE_W-1:0] dc_offset;
    logic [THRESH_W-1:0] threshold;
    logic [NOTE_W-1:0]   note;
    logic [STATUS_W-1:0] status;
  } cfg_t;

  // one note-on packet
  typedef struct packed {
    logic [STATUS_W-1:0] packet_header;
    logic [STATUS_W-1:0] status;
    logic [NOTE_W-1:0]   note;
    logic [VEL_W-1:0]    velocity;
  } result_t;

  // input stage status toward the top level
  typedef struct packed {
    logic busy;
    logic emit;
  } det_status_t;

endpackage

`default_nettype wire

// File: sv/drum_trigger_peak_detector_unit.sv
// ----------------------------------------------------------------------------
// drum_trigger_peak_detector_unit
// Drum pad peak detector emitting USB-MIDI note-on packets.
// ----------------------------------------------------------------------------
// One 10-bit sample is accepted per clock cycle while in_ready is high. A
// sample lands in the input register, where the offset, clip, slope and peak
// logic run combinationally; a qualifying peak then loads the result register,
// which drives out_valid. Samples that cause no packet never stall. A packet
// that finds the result register still full waits in the input register, and
// in_ready drops only then, until the sink takes the result register's packet.
// The user must write configuration through the APB port while the block is
// idle; the block does not enforce it. Registers are at bytes 0, 4, 8 and 12.
`default_nettype none

`include "drum_trigger_peak_detector_unit_defines.svh"

module drum_trigger_peak_detector_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // sample channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [dtpd_pkg::SAMPLE_W-1:0] in_sample,
  // packet channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [dtpd_pkg::STATUS_W-1:0]      out_packet_header,
  output logic [dtpd_pkg::STATUS_W-1:0]      out_status,
  output logic [dtpd_pkg::NOTE_W-1:0]        out_note,
  output logic [dtpd_pkg::VEL_W-1:0]         out_velocity,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dtpd_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [dtpd_pkg::DATA_W-1:0]   pwdata,
  output logic      [dtpd_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);

  dtpd_pkg::cfg_t        cfg;
  dtpd_pkg::result_t     res;
  dtpd_pkg::det_status_t stat;
  logic                  res_valid;
  logic                  res_ready;

  // configuration registers
  dtpd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register and detection
  dtpd_detect u_detect (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .stat      (stat)
  );

  // result register
  dtpd_outbuf u_outbuf (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_valid         (res_valid),
    .res_ready         (res_ready),
    .res               (res),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_packet_header (out_packet_header),
    .out_status        (out_status),
    .out_note          (out_note),
    .out_velocity      (out_velocity)
  );

  // checks
  `DTPD_ASSERT_IMPL(a_ready_only_when_busy, !in_ready, stat.busy, "in_ready low with empty input stage")
  `DTPD_ASSERT_NEXT(a_blocked_packet_held, (stat.busy && stat.emit && out_valid && !out_ready), stat.busy, "blocked packet left input stage")
  `DTPD_ASSERT_IMPL(a_header_swapped, out_valid, (out_packet_header == {out_status[3:0], out_status[7:4]}), "packet header is not the swapped status")
  `DTPD_ASSERT_IMPL(a_velocity_above_threshold, out_valid, (out_velocity > cfg.threshold), "packet sent at or below threshold")

endmodule

`default_nettype wire

// File: sv/dtpd_regs.sv
// ----------------------------------------------------------------------------
// dtpd_regs
// APB-style configuration registers: offset, threshold, note and status.
// ----------------------------------------------------------------------------
`default_nettype none

module dtpd_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dtpd_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [dtpd_pkg::DATA_W-1:0]   pwdata,
  output logic      [dtpd_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output dtpd_pkg::cfg_t                     cfg
);

  logic [dtpd_pkg::SAMPLE_W-1:0] dc_offset_r;
  logic [dtpd_pkg::THRESH_W-1:0] threshold_r;
  logic [dtpd_pkg::NOTE_W-1:0]   note_r;
  logic [dtpd_pkg::STATUS_W-1:0] status_r;
  logic [1:0]                    reg_idx;
  logic                          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_offset_r <= dtpd_pkg::RST_DC_OFFSET;
      threshold_r <= dtpd_pkg::RST_THRESHOLD;
      note_r      <= dtpd_pkg::RST_NOTE;
      status_r    <= dtpd_pkg::RST_STATUS;
    end else if (wr_en) begin
      case (reg_idx)
        dtpd_pkg::REG_DC_OFFSET: dc_offset_r <= pwdata[dtpd_pkg::SAMPLE_W-1:0];
        dtpd_pkg::REG_THRESHOLD: threshold_r <= pwdata[dtpd_pkg::THRESH_W-1:0];
        dtpd_pkg::REG_NOTE:      note_r      <= pwdata[dtpd_pkg::NOTE_W-1:0];
        dtpd_pkg::REG_STATUS:    status_r    <= pwdata[dtpd_pkg::STATUS_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      dtpd_pkg::REG_DC_OFFSET: prdata = {22'd0, dc_offset_r};
      dtpd_pkg::REG_THRESHOLD: prdata = {25'd0, threshold_r};
      dtpd_pkg::REG_NOTE:      prdata = {25'd0, note_r};
      dtpd_pkg::REG_STATUS:    prdata = {24'd0, status_r};
      default:                 prdata = '0;
    endcase
  end

  assign cfg.dc_offset = dc_offset_r;
  assign cfg.threshold = threshold_r;
  assign cfg.note      = note_r;
  assign cfg.status    = status_r;

endmodule

`default_nettype wire

// File: sv/dtpd_detect.sv
// ----------------------------------------------------------------------------
// dtpd_detect
// Input register plus level, slope and peak logic with the slope history.
// ----------------------------------------------------------------------------
`default_nettype none

module dtpd_detect (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [dtpd_pkg::SAMPLE_W-1:0]   in_sample,
  input  wire dtpd_pkg::cfg_t                  cfg,
  output logic                                 res_valid,
  input  wire logic                            res_ready,
  output dtpd_pkg::result_t                    res,
  output dtpd_pkg::det_status_t                stat
);

  logic                          s1_valid_r;
  logic                          s1_valid_nxt;
  logic [dtpd_pkg::SAMPLE_W-1:0] sample_r;
  logic [dtpd_pkg::LEVEL_W-1:0]  prev_level_r;
  logic [dtpd_pkg::SLOPE_W-1:0]  slope_mid_r;
  logic [dtpd_pkg::SLOPE_W-1:0]  slope_old_r;

  logic [dtpd_pkg::SAMPLE_W-1:0] diff;
  logic [dtpd_pkg::LEVEL_W-1:0]  level;
  logic [dtpd_pkg::LEVEL_W-1:0]  rise;
  logic [dtpd_pkg::SLOPE_W-1:0]  slope;
  logic [dtpd_pkg::VEL_W-1:0]    velocity;
  logic                          peak;
  logic                          emit;
  logic                          in_acc;
  logic                          advance;

  // level: offset removed, clipped to 0..511
  assign diff  = sample_r - cfg.dc_offset;
  always_comb begin
    if (sample_r <= cfg.dc_offset) begin
      level = '0;
    end else if (diff[dtpd_pkg::SAMPLE_W-1]) begin
      level = dtpd_pkg::LEVEL_MAX;
    end else begin
      level = diff[dtpd_pkg::LEVEL_W-1:0];
    end
  end

  // slope: rising part only, quartered
  assign rise     = (level > prev_level_r) ? (level - prev_level_r) : '0;
  assign slope    = rise[dtpd_pkg::LEVEL_W-1:2];
  assign velocity = level[dtpd_pkg::LEVEL_W-1:2];

  // peak when the middle slope tops both neighbors
  assign peak = (slope_mid_r > slope) && (slope_mid_r > slope_old_r);
  assign emit = peak && (velocity > cfg.threshold);

  // handshake
  assign advance   = s1_valid_r && (!emit || res_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign in_acc    = in_valid && in_ready;
  assign res_valid = s1_valid_r && emit;

  always_comb begin
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_sample;
    end
  end

  // history moves when the stage hands its transaction on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= '0;
      slope_mid_r  <= '0;
      slope_old_r  <= '0;
    end else if (advance) begin
      prev_level_r <= level;
      slope_mid_r  <= slope;
      slope_old_r  <= slope_mid_r;
    end
  end

  // packet fields
  assign res.packet_header = {cfg.status[3:0], cfg.status[7:4]};
  assign res.status        = cfg.status;
  assign res.note          = cfg.note;
  assign res.velocity      = velocity;

  assign stat.busy = s1_valid_r;
  assign stat.emit = emit;

endmodule

`default_nettype wire

// File: sv/dtpd_outbuf.sv
// ----------------------------------------------------------------------------
// dtpd_outbuf
// Result register holding one note-on packet until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dtpd_outbuf (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          res_valid,
  output logic                               res_ready,
  input  wire dtpd_pkg::result_t             res,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [dtpd_pkg::STATUS_W-1:0]      out_packet_header,
  output logic [dtpd_pkg::STATUS_W-1:0]      out_status,
  output logic [dtpd_pkg::NOTE_W-1:0]        out_note,
  output logic [dtpd_pkg::VEL_W-1:0]         out_velocity
);

  logic              out_valid_r;
  logic              out_valid_nxt;
  dtpd_pkg::result_t data_r;
  logic              load;

  assign res_ready = !out_valid_r || out_ready;
  assign load      = res_valid && res_ready;

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_packet_header = data_r.packet_header;
  assign out_status        = data_r.status;
  assign out_note          = data_r.note;
  assign out_velocity      = data_r.velocity;

endmodule

`default_nettype wire

// File: tb/drum_trigger_peak_detector_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drum_trigger_peak_detector_unit_test
// Self-checking bench for the drum trigger peak detector. Drum strikes and
// noise go in as sample transactions. A local model of the level, slope and
// peak logic predicts each note-on packet, and the packets that come out are
// checked field by field in order. The run covers several register settings,
// random stalls on both channels, a drain pause and one stretch with no stalls.
// ----------------------------------------------------------------------------
module drum_trigger_peak_detector_unit_test;

  localparam int STALL_PCT      = 20;
  localparam int DRAIN_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [dtpd_pkg::SAMPLE_W-1:0] in_sample;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [dtpd_pkg::STATUS_W-1:0] out_packet_header;
  logic [dtpd_pkg::STATUS_W-1:0] out_status;
  logic [dtpd_pkg::NOTE_W-1:0]   out_note;
  logic [dtpd_pkg::VEL_W-1:0]    out_velocity;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [dtpd_pkg::ADDR_W-1:0]   paddr;
  logic [dtpd_pkg::DATA_W-1:0]   pwdata;
  logic [dtpd_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  // model of the block: registers, level and slope history
  dtpd_pkg::cfg_t               model_cfg;
  logic [dtpd_pkg::LEVEL_W-1:0] last_level;
  logic [dtpd_pkg::SLOPE_W-1:0] newest_slope;
  logic [dtpd_pkg::SLOPE_W-1:0] older_slope;

  dtpd_pkg::result_t pending_packets[$];
  dtpd_pkg::result_t head_packet;
  int      mismatches     = 0;
  int      samples_sent   = 0;
  int      stalled_cycles = 0;
  logic    steady         = 1'b0;

  always #5 clk = ~clk;

  drum_trigger_peak_detector_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_packet_header (out_packet_header),
    .out_status        (out_status),
    .out_note          (out_note),
    .out_velocity      (out_velocity),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // random stall decision, off during the steady stretch
  function automatic logic take_break();
    return !steady && ($urandom_range(99) < STALL_PCT);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got 0x%0h want 0x%0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic reset_model();
    model_cfg.dc_offset = dtpd_pkg::RST_DC_OFFSET;
    model_cfg.threshold = dtpd_pkg::RST_THRESHOLD;
    model_cfg.note      = dtpd_pkg::RST_NOTE;
    model_cfg.status    = dtpd_pkg::RST_STATUS;
    last_level   = '0;
    newest_slope = '0;
    older_slope  = '0;
  endtask

  // level, slope and peak of one accepted sample; queues a note-on on a hit
  task automatic predict_note_on(input logic [dtpd_pkg::SAMPLE_W-1:0] smp);
    logic [dtpd_pkg::SAMPLE_W-1:0] diff;
    logic [dtpd_pkg::LEVEL_W-1:0]  lvl;
    logic [dtpd_pkg::LEVEL_W-1:0]  rise;
    logic [dtpd_pkg::SLOPE_W-1:0]  slope;
    logic [dtpd_pkg::VEL_W-1:0]    vel;
    logic                          is_peak;
    dtpd_pkg::result_t             pkt;
    // offset removal, clipped to 0..511
    if (smp <= model_cfg.dc_offset) begin
      lvl = '0;
    end else begin
      diff = smp - model_cfg.dc_offset;
      lvl  = (diff > dtpd_pkg::LEVEL_MAX) ? dtpd_pkg::LEVEL_MAX
                                          : diff[dtpd_pkg::LEVEL_W-1:0];
    end
    // falling level gives a zero slope
    rise  = (lvl > last_level) ? lvl - last_level : '0;
    slope = rise[dtpd_pkg::LEVEL_W-1:2];
    vel   = lvl[dtpd_pkg::LEVEL_W-1:2];
    is_peak = (newest_slope > slope) && (newest_slope > older_slope);
    last_level   = lvl;
    older_slope  = newest_slope;
    newest_slope = slope;
    // quiet peaks are dropped
    if (is_peak && vel > model_cfg.threshold) begin
      pkt.packet_header = {model_cfg.status[3:0], model_cfg.status[7:4]};
      pkt.status        = model_cfg.status;
      pkt.note          = model_cfg.note;
      pkt.velocity      = vel;
      pending_packets.push_back(pkt);
    end
  endtask

  // one sample transaction, with a random gap ahead of it
  task automatic send_sample(input logic [dtpd_pkg::SAMPLE_W-1:0] smp);
    @(negedge clk);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= smp;
    do @(posedge clk); while (!in_ready);
    predict_note_on(smp);
    samples_sent++;
  endtask

  // sample at a given level above the current offset
  task automatic send_level(input int lvl);
    int raw;
    raw = int'(model_cfg.dc_offset) + lvl;
    if (raw < 0) raw = 0;
    if (raw > 1023) raw = 1023;
    send_sample(raw[dtpd_pkg::SAMPLE_W-1:0]);
  endtask

  // stop sending, wait for every pending packet, then let the pipe empty
  task automatic settle_block(input int extra_cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_packets.size() != 0) @(posedge clk);
    repeat (extra_cycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [dtpd_pkg::DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      dtpd_pkg::REG_DC_OFFSET: model_cfg.dc_offset = value[dtpd_pkg::SAMPLE_W-1:0];
      dtpd_pkg::REG_THRESHOLD: model_cfg.threshold = value[dtpd_pkg::THRESH_W-1:0];
      dtpd_pkg::REG_NOTE:      model_cfg.note      = value[dtpd_pkg::NOTE_W-1:0];
      dtpd_pkg::REG_STATUS:    model_cfg.status    = value[dtpd_pkg::STATUS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input logic [1:0] idx);
    logic [dtpd_pkg::DATA_W-1:0] want;
    want = '0;
    case (idx)
      dtpd_pkg::REG_DC_OFFSET: want[dtpd_pkg::SAMPLE_W-1:0] = model_cfg.dc_offset;
      dtpd_pkg::REG_THRESHOLD: want[dtpd_pkg::THRESH_W-1:0] = model_cfg.threshold;
      dtpd_pkg::REG_NOTE:      want[dtpd_pkg::NOTE_W-1:0]   = model_cfg.note;
      default:                 want[dtpd_pkg::STATUS_W-1:0] = model_cfg.status;
    endcase
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) report_mismatch($sformatf("register %0d readback", idx), prdata, want);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // all four registers, with junk above each field, then read back
  task automatic apply_settings(input int dc, input int thr, input int note, input int stat);
    settle_block(DRAIN_CYCLES);
    write_reg(dtpd_pkg::REG_DC_OFFSET, ($urandom << dtpd_pkg::SAMPLE_W) | dc);
    write_reg(dtpd_pkg::REG_THRESHOLD, ($urandom << dtpd_pkg::THRESH_W) | thr);
    write_reg(dtpd_pkg::REG_NOTE,      ($urandom << dtpd_pkg::NOTE_W) | note);
    write_reg(dtpd_pkg::REG_STATUS,    ($urandom << dtpd_pkg::STATUS_W) | stat);
    for (int i = 0; i < 4; i++) check_reg(2'(i));
  endtask

  // quiet lead-in, a rise of one to four samples, then a decay
  task automatic play_strike();
    int top;
    int rise_len;
    int decay_len;
    top       = $urandom_range(511);
    rise_len  = $urandom_range(4, 1);
    decay_len = $urandom_range(8, 2);
    repeat ($urandom_range(3, 1)) send_level($urandom_range(6));
    for (int k = 1; k <= rise_len; k++)
      send_level(top * k / rise_len + int'($urandom_range(8)) - 4);
    for (int k = decay_len - 1; k >= 0; k--)
      send_level(top * k / decay_len + int'($urandom_range(8)) - 4);
  endtask

  task automatic play_noise();
    int raw;
    repeat ($urandom_range(6, 1)) begin
      raw = $urandom_range(1023);
      send_sample(raw[dtpd_pkg::SAMPLE_W-1:0]);
    end
  endtask

  // mostly well-formed strikes, some raw noise
  task automatic play_phase(input int n_items);
    int stop_at;
    stop_at = samples_sent + n_items;
    while (samples_sent < stop_at) begin
      if ($urandom_range(99) < 85) play_strike();
      else play_noise();
    end
  endtask

  task automatic test_reset_values();
    for (int i = 0; i < 4; i++) check_reg(2'(i));
  endtask

  task automatic test_directed_samples();
    // default offset: below offset, full clip, falling level, plain hit
    send_sample(10'd512);
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd1023);
    send_sample(10'd700);
    send_sample(10'd512);
    send_sample(10'd520);
    send_sample(10'd600);
    send_sample(10'd600);
    // zero offset: velocity at the threshold, then one above it
    apply_settings(0, dtpd_pkg::RST_THRESHOLD, dtpd_pkg::RST_NOTE, dtpd_pkg::RST_STATUS);
    send_sample(10'd0);
    send_sample(10'd0);
    send_sample(10'd20);
    send_sample(10'd20);
    send_sample(10'd0);
    send_sample(10'd0);
    send_sample(10'd24);
    send_sample(10'd24);
  endtask

  task automatic test_setting_extremes();
    apply_settings(0, 0, 0, 8'h80);
    play_phase(15);
    apply_settings(1023, 127, 127, 8'hFF);
    play_phase(15);
    // status byte below 128 is passed through as written
    apply_settings(0, 127, 0, 8'h05);
    play_phase(15);
    apply_settings(300, 0, 127, 8'h00);
    play_phase(15);
    apply_settings(dtpd_pkg::RST_DC_OFFSET, dtpd_pkg::RST_THRESHOLD, dtpd_pkg::RST_NOTE,
                   dtpd_pkg::RST_STATUS);
    play_phase(15);
  endtask

  task automatic test_random_strikes();
    int dc;
    for (int ph = 0; ph < 5; ph++) begin
      case ($urandom_range(5))
        0:       dc = 0;
        1:       dc = 1023;
        2:       dc = $urandom_range(1023);
        default: dc = $urandom_range(640, 256);
      endcase
      apply_settings(dc, $urandom_range(40), $urandom_range(127), $urandom_range(255));
      if (ph == 2) begin
        // sender holds off until every packet is out
        play_phase(50);
        settle_block(0);
        play_phase(50);
      end else begin
        play_phase(100);
      end
    end
  endtask

  task automatic test_steady_stream();
    apply_settings($urandom_range(600, 400), $urandom_range(10), $urandom_range(127),
                   $urandom_range(255, 128));
    steady = 1'b1;
    play_phase(70);
    settle_block(DRAIN_CYCLES);
    steady = 1'b0;
  endtask

  // sink side with random stalls
  always @(negedge clk) out_ready <= steady || ($urandom_range(99) >= STALL_PCT);

  // compare each packet transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_packets.size() == 0) begin
        report_mismatch("packet with none pending", out_velocity, 0);
      end else begin
        head_packet = pending_packets.pop_front();
        if (out_packet_header !== head_packet.packet_header)
          report_mismatch("packet_header", out_packet_header, head_packet.packet_header);
        if (out_status !== head_packet.status)
          report_mismatch("status", out_status, head_packet.status);
        if (out_note !== head_packet.note)
          report_mismatch("note", out_note, head_packet.note);
        if (out_velocity !== head_packet.velocity)
          report_mismatch("velocity", out_velocity, head_packet.velocity);
      end
    end
  end

  // watchdog on cycles with no transaction anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("** drum_trigger_peak_detector_unit: FAILED **");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_sample = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    reset_model();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_directed_samples();
    test_setting_extremes();
    test_random_strikes();
    test_steady_stream();

    settle_block(10);
    if (mismatches == 0 && pending_packets.size() == 0) begin
      $display("** drum_trigger_peak_detector_unit: PASSED **");
    end else begin
      $display("** drum_trigger_peak_detector_unit: FAILED **");
    end
    $finish;
  end

endmodule
